### hdl/cht_pkg.sv
// shared types and request/status codes for the chained hash table
package cht_pkg;

    typedef enum logic [1:0] {
        REQ_PUT    = 2'd0,
        REQ_REMOVE = 2'd1,
        REQ_GET    = 2'd2,
        REQ_NONE   = 2'd3
    } req_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NOTFOUND = 2'd1,
        ST_FULL     = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        DP_NOP,
        DP_LOAD,
        DP_PUT,
        DP_READ,
        DP_STEP,
        DP_UNLINK,
        DP_OUT
    } dp_cmd_t;

    typedef struct packed {
        logic    empty_pool;
        logic    at_null;
        logic    hit;
        logic    clearing;
        req_t    req;
    } dp_status_t;

endpackage

### hdl/cht_ram.sv
// generic single-port-write, single-read ram with registered read
module cht_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

### hdl/cht_datapath.sv
// datapath: bucket heads, node memories, free stack and chain walk registers
module cht_datapath #(
    parameter int BUCKETS = 128,
    parameter int NODES   = 256
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  cht_pkg::dp_cmd_t       cmd,
    input  logic [1:0]             in_req,
    input  logic [15:0]            in_key,
    input  logic [31:0]            in_value,
    output cht_pkg::dp_status_t    stat,
    output logic [1:0]             res_status,
    output logic [31:0]            res_value
);
    import cht_pkg::*;

    localparam int NW = $clog2(NODES);
    localparam int PW = NW + 1;
    localparam int BW = $clog2(BUCKETS);
    localparam int CW = $clog2(NODES + 1);
    localparam int SW = $clog2(NODES + 1);
    localparam logic [PW-1:0] NULL_PTR = PW'(NODES);

    logic [1:0]    req_reg;
    logic [15:0]   key_reg;
    logic [31:0]   value_reg;
    logic [BW-1:0] bucket_reg;
    logic [PW-1:0] cur_reg;
    logic [PW-1:0] prev_reg;
    logic [CW-1:0] free_count_reg;
    logic [SW-1:0] steps_reg;
    logic [NW:0]   clr_reg;
    logic          found_reg;
    logic [31:0]   out_value_reg;

    logic [BW-1:0] bucket;
    logic [BW-1:0] head_raddr;
    logic          hw_we;
    logic [BW-1:0] hw_addr;
    logic [PW-1:0] hw_data;
    logic [PW-1:0] head_rd;
    logic          nk_we;
    logic [NW-1:0] nk_waddr;
    logic [15:0]   nk_rd;
    logic [31:0]   nv_rd;
    logic          nn_we;
    logic [NW-1:0] nn_waddr;
    logic [PW-1:0] nn_wdata;
    logic [PW-1:0] nn_rd;
    logic [NW-1:0] node_raddr;
    logic          fs_we;
    logic [NW-1:0] fs_waddr;
    logic [NW-1:0] fs_wdata;
    logic [NW-1:0] fs_raddr;
    logic [NW-1:0] fs_rd;
    logic [PW-1:0] cur_link;
    logic [PW-1:0] next_link;

    assign bucket     = BW'(in_key % 16'(BUCKETS));
    assign head_raddr = (cmd == DP_LOAD) ? bucket : bucket_reg;

    // head after the mark, valid only as a node index
    assign cur_link  = (head_rd < NULL_PTR) ? head_rd : NULL_PTR;
    assign next_link = (nn_rd < NULL_PTR) ? nn_rd : NULL_PTR;

    // memories read at the current walk node
    assign node_raddr = (cmd == DP_READ) ? cur_link[NW-1:0] :
                        (cmd == DP_STEP) ? next_link[NW-1:0] : cur_reg[NW-1:0];

    // head store with clearing pass
    logic [BW:0] hclr_reg;
    assign hw_we   = ~hclr_reg[BW] || (cmd == DP_PUT && free_count_reg != '0) ||
                     (cmd == DP_UNLINK && prev_reg == NULL_PTR);
    assign hw_addr = ~hclr_reg[BW] ? hclr_reg[BW-1:0] : bucket_reg;
    assign hw_data = ~hclr_reg[BW] ? NULL_PTR :
                     (cmd == DP_PUT) ? PW'(fs_rd) : next_link;

    cht_ram #(.WIDTH(PW), .DEPTH(BUCKETS)) u_head (
        .clk(clk), .we(hw_we), .waddr(hw_addr), .wdata(hw_data),
        .raddr(head_raddr), .rdata(head_rd)
    );

    assign nk_we    = (cmd == DP_PUT) && free_count_reg != '0;
    assign nk_waddr = fs_rd;

    cht_ram #(.WIDTH(16), .DEPTH(NODES)) u_key (
        .clk(clk), .we(nk_we), .waddr(nk_waddr), .wdata(key_reg),
        .raddr(node_raddr), .rdata(nk_rd)
    );
    cht_ram #(.WIDTH(32), .DEPTH(NODES)) u_val (
        .clk(clk), .we(nk_we), .waddr(nk_waddr), .wdata(value_reg),
        .raddr(node_raddr), .rdata(nv_rd)
    );

    assign nn_we    = nk_we || (cmd == DP_UNLINK && prev_reg != NULL_PTR);
    assign nn_waddr = nk_we ? fs_rd : prev_reg[NW-1:0];
    assign nn_wdata = nk_we ? cur_link : next_link;

    cht_ram #(.WIDTH(PW), .DEPTH(NODES)) u_next (
        .clk(clk), .we(nn_we), .waddr(nn_waddr), .wdata(nn_wdata),
        .raddr(node_raddr), .rdata(nn_rd)
    );

    // free stack, filled by the clearing pass and pushed on unlink
    assign fs_we    = ~clr_reg[NW] || (cmd == DP_UNLINK);
    assign fs_waddr = ~clr_reg[NW] ? clr_reg[NW-1:0] : NW'(free_count_reg);
    assign fs_wdata = ~clr_reg[NW] ? clr_reg[NW-1:0] : cur_reg[NW-1:0];
    assign fs_raddr = NW'(free_count_reg - CW'(1));

    cht_ram #(.WIDTH(NW), .DEPTH(NODES)) u_free (
        .clk(clk), .we(fs_we), .waddr(fs_waddr), .wdata(fs_wdata),
        .raddr(fs_raddr), .rdata(fs_rd)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg        <= '0;
            hclr_reg       <= '0;
            free_count_reg <= CW'(NODES);
            found_reg      <= 1'b0;
            cur_reg        <= NULL_PTR;
            prev_reg       <= NULL_PTR;
            steps_reg      <= '0;
        end
        else
        begin
            if (~clr_reg[NW])
            begin
                clr_reg <= clr_reg + (NW+1)'(1);
            end
            if (~hclr_reg[BW])
            begin
                hclr_reg <= hclr_reg + (BW+1)'(1);
            end
            case (cmd)
                DP_LOAD:
                begin
                    found_reg <= 1'b0;
                    prev_reg  <= NULL_PTR;
                    steps_reg <= '0;
                end
                DP_PUT:
                begin
                    if (free_count_reg != '0)
                    begin
                        free_count_reg <= free_count_reg - CW'(1);
                        found_reg      <= 1'b1;
                    end
                end
                DP_READ:
                begin
                    cur_reg <= cur_link;
                end
                DP_STEP:
                begin
                    prev_reg  <= cur_reg;
                    cur_reg   <= next_link;
                    steps_reg <= steps_reg + SW'(1);
                end
                DP_UNLINK:
                begin
                    free_count_reg <= free_count_reg + CW'(1);
                    found_reg      <= 1'b1;
                end
                default:
                begin
                end
            endcase
            if (cmd == DP_OUT && req_reg == REQ_GET && stat.hit)
            begin
                found_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd == DP_LOAD)
        begin
            req_reg    <= in_req;
            key_reg    <= in_key;
            value_reg  <= in_value;
            bucket_reg <= bucket;
        end
        if (cmd == DP_OUT)
        begin
            out_value_reg <= (req_reg == REQ_GET && stat.hit) ? nv_rd : 32'd0;
        end
    end

    assign stat.empty_pool = (free_count_reg == '0);
    assign stat.at_null    = (cur_reg == NULL_PTR) || (steps_reg == SW'(NODES));
    assign stat.hit        = (cur_reg != NULL_PTR) && (nk_rd == key_reg);
    assign stat.clearing   = ~clr_reg[NW] || ~hclr_reg[BW];
    assign stat.req        = req_t'(req_reg);

    assign res_status = found_reg ? ST_OK :
                        (req_reg == REQ_PUT) ? ST_FULL : ST_NOTFOUND;
    assign res_value  = out_value_reg;
endmodule

### hdl/cht_ctrl.sv
// controller: sequences put, chain walk and unlink, holds the output beat
module cht_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    input  cht_pkg::dp_status_t   stat,
    output cht_pkg::dp_cmd_t      cmd
);
    import cht_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DISPATCH,
        S_HEAD,
        S_READ,
        S_CHECK,
        S_FIN,
        S_DONE
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   m_tvalid_reg;
    logic   m_tvalid_next;

    assign s_tready = (state_reg == S_IDLE) && !stat.clearing && !m_tvalid_reg;
    assign m_tvalid = m_tvalid_reg;

    always_comb
    begin
        state_next    = state_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        cmd           = DP_NOP;
        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid && s_tready)
                begin
                    cmd        = DP_LOAD;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                if (stat.req == REQ_PUT)
                begin
                    cmd        = DP_PUT;
                    state_next = S_FIN;
                end
                else if (stat.req == REQ_NONE)
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    state_next = S_HEAD;
                end
            end
            S_HEAD:
            begin
                cmd        = DP_READ;
                state_next = S_CHECK;
            end
            S_READ:
            begin
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                if (stat.at_null)
                begin
                    state_next = S_FIN;
                end
                else if (stat.hit)
                begin
                    if (stat.req == REQ_REMOVE)
                    begin
                        cmd = DP_UNLINK;
                    end
                    state_next = S_FIN;
                end
                else
                begin
                    cmd        = DP_STEP;
                    state_next = S_READ;
                end
            end
            S_FIN:
            begin
                cmd        = DP_OUT;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                m_tvalid_next = 1'b1;
                state_next    = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready |-> state_reg == S_IDLE && !m_tvalid_reg)
        else $error("accept while busy");
    a_done_valid: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_DONE |=> m_tvalid_reg)
        else $error("result beat missing");
    a_out_after_fin: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_FIN |=> state_reg == S_DONE)
        else $error("finish sequence broken");
endmodule

### hdl/chained_hash_table.sv
// chained_hash_table: top level of the separate-chaining key-value store
// sequence: put runs dispatch, fin and done states; get/remove run dispatch, head, check, then fin and done
// throughput: one request at a time; next beat accepted once the result beat is taken
// the chain walk is set by the registered read of the node memories, a read and a check state per node
// reset: async active low; free stack and bucket heads are cleared by a sweep over
// all NODES and BUCKETS entries after reset, during which no request is accepted
module chained_hash_table #(
    parameter int BUCKETS = 128,
    parameter int NODES   = 256
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [55:0] s_tdata,   // req_type[1:0], key[17:2], value[49:18], zero fill
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata    // status[1:0], found_value[33:2], zero fill
);
    import cht_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t stat;
    logic [1:0]  res_status;
    logic [31:0] res_value;

    cht_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready),
        .m_tvalid(m_tvalid), .m_tready(m_tready),
        .stat(stat), .cmd(cmd)
    );

    cht_datapath #(.BUCKETS(BUCKETS), .NODES(NODES)) u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd),
        .in_req(s_tdata[1:0]), .in_key(s_tdata[17:2]), .in_value(s_tdata[49:18]),
        .stat(stat), .res_status(res_status), .res_value(res_value)
    );

    assign m_tdata = {6'd0, res_value, res_status};
endmodule

### test/tb_chk.sv
// checker for the chained hash table: predicts each result and compares it
`timescale 1ns / 1ps
module tb_chk
    import cht_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [55:0] s_tdata,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [39:0] m_tdata,
    output int          fails,
    output int          pending
);

    localparam int BUCKETS = 128;
    localparam int NODES   = 256;

    typedef struct packed {
        status_t     st;
        logic [31:0] val;
    } answer_t;

    // per-bucket chains, newest first
    typedef struct {
        logic [15:0] k;
        logic [31:0] v;
    } entry_t;

    entry_t  chain [BUCKETS][$];
    int      used;
    answer_t answers [$];

    assign pending = answers.size();

    function automatic answer_t predict_table(logic [1:0] req, logic [15:0] k, logic [31:0] v);
        answer_t a;
        int      b;
        entry_t  e;
        a.st  = ST_NOTFOUND;
        a.val = '0;
        b     = k % BUCKETS;
        if (req == REQ_PUT) begin
            if (used >= NODES) begin
                a.st = ST_FULL;
            end
            else begin
                e.k = k;
                e.v = v;
                chain[b].push_front(e);
                used++;
                a.st = ST_OK;
            end
        end
        else if (req == REQ_REMOVE || req == REQ_GET) begin
            foreach (chain[b][i]) begin
                if (chain[b][i].k == k) begin
                    a.st = ST_OK;
                    if (req == REQ_GET) begin
                        a.val = chain[b][i].v;
                    end
                    else begin
                        chain[b].delete(i);
                        used--;
                    end
                    break;
                end
            end
        end
        return a;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        answer_t exp_a;
        if (!rst_n) begin
            fails = 0;
            used  = 0;
            answers.delete();
            for (int i = 0; i < BUCKETS; i++)
                chain[i].delete();
        end
        else begin
            if (s_tvalid && s_tready)
                answers.push_back(predict_table(s_tdata[1:0], s_tdata[17:2], s_tdata[49:18]));
            if (m_tvalid && m_tready) begin
                if (answers.size() == 0) begin
                    fails++;
                    if (fails <= 10)
                        $display("unexpected result beat: status %0d value %0d",
                                 m_tdata[1:0], $signed(m_tdata[33:2]));
                end
                else begin
                    exp_a = answers.pop_front();
                    if (m_tdata[1:0] !== exp_a.st || m_tdata[33:2] !== exp_a.val
                        || m_tdata[39:34] !== '0) begin
                        fails++;
                        if (fails <= 10)
                            $display("mismatch: expected status %0d value %0d, got status %0d value %0d",
                                     exp_a.st, $signed(exp_a.val), m_tdata[1:0],
                                     $signed(m_tdata[33:2]));
                    end
                end
            end
        end
    end

endmodule

### test/tb_top.sv
// testbench top for the chained hash table: stimulus, watchdog and verdict
`timescale 1ns / 1ps
module tb_top;
    import cht_pkg::*;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [55:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;
    int          fails;
    int          pending;
    int          idle_cycles;
    bit          calm;
    logic [15:0] recent [$];

    always #6 clk = ~clk;

    chained_hash_table dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    tb_chk chk (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .fails(fails), .pending(pending)
    );

    // result side stalls at random, except while calm
    always @(posedge clk)
        m_tready <= calm ? 1'b1 : ($urandom_range(99) >= 23);

    // watchdog on cycles with no accepted beat
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 20000) begin
            $display("simulation failed");
            $finish;
        end
    end

    task automatic send_beat(logic [1:0] req, logic [15:0] k, logic [31:0] v);
        while (!calm && $urandom_range(99) < 23) begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {6'd0, v, k, req};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        if (req == REQ_PUT) begin
            recent.push_back(k);
            if (recent.size() > 64)
                void'(recent.pop_front());
        end
    endtask

    function automatic logic [15:0] pick_key();
        if (recent.size() > 0 && $urandom_range(99) < 60)
            return recent[$urandom_range(recent.size() - 1)];
        if ($urandom_range(1))
            return 16'($urandom_range(3) * 128 + $urandom_range(7));
        return 16'($urandom);
    endfunction

    initial begin
        calm = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        // directed: field extremes, duplicates, misses, unused code
        send_beat(REQ_GET, 16'h0000, 32'h0);
        send_beat(REQ_REMOVE, 16'hffff, 32'h0);
        send_beat(REQ_PUT, 16'h0000, 32'h7fffffff);
        send_beat(REQ_PUT, 16'hffff, 32'h80000000);
        send_beat(REQ_PUT, 16'h0000, 32'hffffffff);
        send_beat(REQ_PUT, 16'h0080, 32'h00000001);
        send_beat(REQ_GET, 16'h0000, 32'h5555aaaa);
        send_beat(REQ_GET, 16'h0080, 32'h0);
        send_beat(REQ_GET, 16'h0100, 32'h0);
        send_beat(REQ_REMOVE, 16'h0000, 32'h0);
        send_beat(REQ_GET, 16'h0000, 32'h0);
        send_beat(REQ_REMOVE, 16'h0000, 32'h0);
        send_beat(REQ_REMOVE, 16'h0000, 32'h0);
        send_beat(REQ_GET, 16'hffff, 32'h0);
        send_beat(REQ_NONE, 16'hffff, 32'hffffffff);
        send_beat(REQ_NONE, 16'h0000, 32'h0);
        // fill the pool past full, then drain part of it
        calm = 1'b1;
        for (int i = 0; i < 260; i++)
            send_beat(REQ_PUT, 16'(i * 37), $urandom);
        for (int i = 0; i < 80; i++)
            send_beat(REQ_REMOVE, pick_key(), $urandom);
        calm = 1'b0;
        // wait for every result before the random part
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        for (int i = 0; i < 1150; i++) begin
            int r;
            logic [1:0] req;
            calm = (i >= 600 && i < 800);
            r = $urandom_range(99);
            req = r < 40 ? REQ_PUT : r < 65 ? REQ_REMOVE : r < 95 ? REQ_GET : REQ_NONE;
            send_beat(req, pick_key(), $urandom);
        end
        calm = 1'b0;
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (600) @(posedge clk);
        if (fails == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

### filelist.f
hdl/cht_pkg.sv
hdl/cht_ram.sv
hdl/cht_datapath.sv
hdl/cht_ctrl.sv
hdl/chained_hash_table.sv
test/tb_chk.sv
test/tb_top.sv
